// ===== design/n3sf_pkg.sv =====
`timescale 1ns / 1ps

package n3sf_pkg;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Register values after reset, and the largest supported height.
  localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RESET = 13'd480;
  localparam logic [12:0] MAX_HEIGHT         = 13'd4096;

  // Result field widths.
  localparam int OUT_COL_W = 11;
  localparam int OUT_ROW_W = 12;
  localparam int SUM_W     = 12;

  // Band limits on the neighbourhood sum.
  localparam logic [SUM_W-1:0] BAND_ZERO_MAX = 12'h100;
  localparam logic [SUM_W-1:0] BAND_LOW_MAX  = 12'h300;
  localparam logic [SUM_W-1:0] BAND_MID_MAX  = 12'h480;
  localparam logic [SUM_W-1:0] BAND_HIGH_MAX = 12'h600;
  localparam logic [SUM_W-1:0] BAND_TOP_MAX  = 12'h800;
  localparam logic [SUM_W-1:0] BAND_FALL_REF = 12'h900;

  localparam logic [7:0] ROLL_HIT = 8'd1;

  // Result queue.
  localparam int RES_FIFO_DEPTH = 4;
  localparam int FIFO_AW        = $clog2(RES_FIFO_DEPTH);
  localparam int FIFO_CNT_W     = FIFO_AW + 1;

  typedef struct packed {
    logic [23:0] pixel;
    logic [2:0]  jitter;
    logic [7:0]  white_roll;
    logic [7:0]  black_roll;
  } pixel_req_t;

  typedef struct packed {
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic [23:0]          out_pixel;
    logic                 last_of_run;
  } result_t;

endpackage

// ===== design/n3sf_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module n3sf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/noisy_3x3_sum_pixel_filter_unit.sv =====
`timescale 1ns / 1ps

// Noisy 3x3 sum pixel filter. Pixels of a frame enter in raster order, one request per clock
// while pixel_ready is high, each with a jitter value and two random roll bytes. The unit
// keeps the previous row of full pixels and the low bytes of the row before that in two line
// memories with a registered read, and a six-byte sliding window in flip-flops. An interior
// pixel is emitted one row and one column late with its low byte changed according to the 3x3
// low-byte sum; border pixels pass unchanged. Pixels of row 0 are emitted at once, pixels of
// row 1 emit nothing unless row 1 is the last row, and pixels of the last row emit a second
// result for themselves, so the stream of results carries every pixel of the frame once. A
// request is taken every clock while each request produces at most one result and results
// are taken; a request of the last row produces two, and since the result port delivers one
// per clock, requests are held off along the last row. A result passes the stage-one
// registers and the four-entry result queue before it is valid on the result port; the queue
// depth sets how far the result side may stall before requests are held off. Writing either
// register restarts the frame at row 0, column 0. The line memories are not cleared after
// reset and need no clearing pass; the frame schedule never uses an entry before it is written.
module noisy_3x3_sum_pixel_filter_unit
  import n3sf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_req_t             pixel_req,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Column counter and line memory address width.
  localparam int CW = $clog2(MAX_WIDTH);
  // Width used when comparing the width register with the largest supported width.
  localparam int XW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

  // The width register is held as (effective width - 1), clamped to the supported range.
  function automatic logic [CW-1:0] width_m1(input logic [11:0] v);
    logic [XW-1:0] ve;
    ve = XW'(v);
    if (v == 12'd0) begin
      return '0;
    end else if (ve > XW'(MAX_WIDTH)) begin
      return CW'(MAX_WIDTH - 1);
    end else begin
      return CW'(ve - XW'(1));
    end
  endfunction

  function automatic logic [OUT_ROW_W-1:0] height_m1(input logic [12:0] v);
    if (v == 13'd0) begin
      return '0;
    end else if (v > MAX_HEIGHT) begin
      return {OUT_ROW_W{1'b1}};
    end else begin
      return OUT_ROW_W'(v - 13'd1);
    end
  endfunction

  // Frame geometry and position of the next request.
  logic [CW-1:0]        w_m1;
  logic [OUT_ROW_W-1:0] h_m1;
  logic [CW-1:0]        col, col_next, col_after;
  logic [OUT_ROW_W-1:0] row, row_next, row_after;
  logic                 accept;
  logic                 row_end;

  // Line memories and window.
  logic [CW-1:0] line_raddr;
  logic [7:0]    top_low;
  logic [23:0]   mid_pixel;
  logic [7:0]    win_low [6];
  logic [23:0]   win_centre;
  logic [23:0]   row_end_pixel;
  logic [SUM_W-1:0] nbr_sum;

  // Stage between the window and the result queue.
  logic                 p1_first, p1_second, p1_filt;
  logic [SUM_W-1:0]     p1_sum;
  logic [23:0]          p1_centre;
  logic [2:0]           p1_jitter;
  logic [7:0]           p1_white, p1_black;
  logic [OUT_COL_W-1:0] p1_col1, p1_col2;
  logic [OUT_ROW_W-1:0] p1_row1, p1_row2;
  logic [23:0]          p1_pix2;
  logic [1:0]           p1_n;
  logic [7:0]           filt_low;

  // Result queue.
  result_t               fifo_mem [RES_FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr, wr_ptr_inc, rd_ptr;
  logic [FIFO_CNT_W-1:0] fifo_count, fifo_count_next;
  logic [FIFO_CNT_W:0]   occupied;
  logic                  pop;
  result_t               entry_first, entry_second;

  // A request is taken only when the queue has room for the two results it may cause,
  // counting those still in the stage ahead of the queue.
  assign p1_n        = {1'b0, p1_first} + {1'b0, p1_second};
  assign occupied    = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(p1_n);
  assign pixel_ready = (occupied <= (FIFO_CNT_W + 1)'(RES_FIFO_DEPTH - 2));
  assign accept      = pixel_valid && pixel_ready;

  assign row_end   = (col == w_m1);
  assign col_after = row_end ? '0 : col + CW'(1);
  assign row_after = row_end ? ((row == h_m1) ? '0 : row + OUT_ROW_W'(1)) : row;

  always_comb begin
    if (cfg_we) begin
      col_next = '0;
      row_next = '0;
    end else if (accept) begin
      col_next = col_after;
      row_next = row_after;
    end else begin
      col_next = col;
      row_next = row;
    end
  end

  // The memories are read one request ahead: the address is the column of the next request,
  // so the data for it sits on the read port by the time it arrives. Along a row wider than one
  // pixel, the next column differs from the column now written, save on a restart at column 0.
  assign line_raddr = rst ? '0 : col_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1 <= width_m1(IMAGE_WIDTH_RESET);
      h_m1 <= height_m1(IMAGE_HEIGHT_RESET);
      col  <= '0;
      row  <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  w_m1 <= width_m1(cfg_data[11:0]);
          REG_IMAGE_HEIGHT: h_m1 <= height_m1(cfg_data);
        endcase
      end
    end
  end

  n3sf_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WIDTH)
  ) u_upper_line (
    .clk  (clk),
    .we   (accept),
    .waddr(col),
    .wdata(mid_pixel[7:0]),
    .raddr(line_raddr),
    .rdata(top_low)
  );

  n3sf_ram #(
    .WIDTH(24),
    .DEPTH(MAX_WIDTH)
  ) u_middle_line (
    .clk  (clk),
    .we   (accept),
    .waddr(col),
    .wdata(pixel_req.pixel),
    .raddr(line_raddr),
    .rdata(mid_pixel)
  );

  // The window holds the low bytes of the two previous columns (top, middle, bottom), so the
  // nine-byte sum is formed as the third column arrives.
  assign nbr_sum = SUM_W'(win_low[0]) + SUM_W'(win_low[1]) + SUM_W'(win_low[2])
                 + SUM_W'(win_low[3]) + SUM_W'(win_low[4]) + SUM_W'(win_low[5])
                 + SUM_W'(top_low) + SUM_W'(mid_pixel[7:0]) + SUM_W'(pixel_req.pixel[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win_low[i] <= '0;
      end
      win_centre <= '0;
    end else if (accept) begin
      win_low[0] <= win_low[3];
      win_low[1] <= win_low[4];
      win_low[2] <= win_low[5];
      win_low[3] <= top_low;
      win_low[4] <= mid_pixel[7:0];
      win_low[5] <= pixel_req.pixel[7:0];
      win_centre <= mid_pixel;
    end
  end

  // The last pixel of a row is kept aside: it is the right border pixel of the row above
  // the one whose first pixel arrives next.
  always_ff @(posedge clk) begin
    if (accept && row_end) begin
      row_end_pixel <= pixel_req.pixel;
    end
  end

  // Stage one: decide which results the request causes and capture what they need.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_first  <= 1'b0;
      p1_second <= 1'b0;
    end else begin
      p1_first  <= accept && (row > OUT_ROW_W'(1));
      p1_second <= accept && ((row == '0) || (row == h_m1));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_filt   <= (col > CW'(1)) && (row > OUT_ROW_W'(1));
      p1_sum    <= nbr_sum;
      p1_centre <= (col == '0) ? row_end_pixel : win_centre;
      p1_jitter <= pixel_req.jitter;
      p1_white  <= pixel_req.white_roll;
      p1_black  <= pixel_req.black_roll;
      p1_col1   <= (col == '0) ? OUT_COL_W'(w_m1) : OUT_COL_W'(col - CW'(1));
      p1_row1   <= row - OUT_ROW_W'(1);
      p1_col2   <= OUT_COL_W'(col);
      p1_row2   <= row;
      p1_pix2   <= pixel_req.pixel;
    end
  end

  // Stage two: band selection on the sum, then the rolls, then saturation to a byte.
  always_comb begin
    logic signed [10:0] v;
    logic signed [10:0] jit;
    logic [SUM_W-1:0]   rise;
    logic [SUM_W-1:0]   fall;
    jit  = $signed({8'b0, p1_jitter});
    rise = p1_sum - BAND_MID_MAX;
    fall = BAND_FALL_REF - p1_sum;
    v    = $signed({3'b0, p1_centre[7:0]});
    priority if (p1_sum <= BAND_ZERO_MAX) begin
      v = '0;
    end else if (p1_sum <= BAND_LOW_MAX) begin
      v = v + $signed({3'b0, p1_sum[11:4]}) + jit;
    end else if (p1_sum <= BAND_MID_MAX) begin
      v = v + $signed({4'b0, p1_sum[11:5]}) + jit;
    end else if (p1_sum <= BAND_HIGH_MAX) begin
      v = v + $signed({3'b0, rise[11:4]}) - jit;
    end else if (p1_sum <= BAND_TOP_MAX) begin
      v = v - $signed({3'b0, fall[11:4]}) - jit;
    end else begin
      v = $signed({4'b0, p1_centre[7:1]});
    end
    if (p1_white == ROLL_HIT) begin
      v = 11'sd255;
    end
    if (p1_black == ROLL_HIT) begin
      v = '0;
    end
    if (v < 11'sd0) begin
      filt_low = 8'd0;
    end else if (v > 11'sd255) begin
      filt_low = 8'hff;
    end else begin
      filt_low = v[7:0];
    end
  end

  always_comb begin
    entry_first.out_col     = p1_col1;
    entry_first.out_row     = p1_row1;
    entry_first.out_pixel   = p1_filt ? {p1_centre[23:8], filt_low} : p1_centre;
    entry_first.last_of_run = !p1_second;
    entry_second.out_col     = p1_col2;
    entry_second.out_row     = p1_row2;
    entry_second.out_pixel   = p1_pix2;
    entry_second.last_of_run = 1'b1;
  end

  // Result queue: up to two pushes and one pop per cycle.
  assign wr_ptr_inc      = wr_ptr + FIFO_AW'(1);
  assign pop             = result_valid && result_ready;
  assign fifo_count_next = fifo_count + FIFO_CNT_W'(p1_n) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (p1_first) begin
      fifo_mem[wr_ptr] <= entry_first;
      if (p1_second) begin
        fifo_mem[wr_ptr_inc] <= entry_second;
      end
    end else if (p1_second) begin
      fifo_mem[wr_ptr] <= entry_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + FIFO_AW'(p1_n);
      rd_ptr     <= rd_ptr + FIFO_AW'(pop);
      fifo_count <= fifo_count_next;
    end
  end

  assign result_valid = (fifo_count != '0);
  assign result       = fifo_mem[rd_ptr];

  // The reservation taken at request time must always cover what reaches the queue.
  assert property (@(posedge clk) disable iff (rst)
    occupied <= (FIFO_CNT_W + 1)'(RES_FIFO_DEPTH))
    else $error("result queue reservation exceeded");

  // A result that is not the last of its run is always followed by its partner in the queue.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_of_run |-> fifo_count >= FIFO_CNT_W'(2))
    else $error("first of two results delivered without its partner queued");

  // A pixel of the second row, when that row is not the last, causes no result.
  assert property (@(posedge clk) disable iff (rst)
    accept && (row == OUT_ROW_W'(1)) && (h_m1 != OUT_ROW_W'(1)) && !cfg_we
    |=> !p1_first && !p1_second)
    else $error("second-row pixel produced a result");

endmodule
